### hw/rtl/fts_pkg.sv
// Shared types and constants of the Fibonacci table search core.
// Holds the controller states and the command and status structs.
// No dependencies; every other file of the block but fts_ram imports it.
package fts_pkg;

   // Default storage geometry.
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int KEY_WIDTH_DEF   = 64;

   // Fixed field widths of the stream and CSR ports.
   localparam int MODE_W     = 1;
   localparam int INDEX_W    = 10;
   localparam int KEY_W      = 64;
   localparam int CSR_W      = 11;
   localparam int POS_W      = 10;
   localparam int PROBE_W    = 5;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 16;

   // Width of Fibonacci terms, search base and probe index (covers 2584).
   localparam int FIB_W = 13;

   // Probe counter ceiling.
   localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

   // Item kinds carried in req_tuser.
   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GROW,
      ST_PROBE_RD,
      ST_PROBE_CMP,
      ST_LAST_RD,
      ST_LAST_CMP,
      ST_FINISH
   } fsm_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write;
      logic start;
      logic grow;
      logic probe_rd;
      logic probe_cmp;
      logic last_rd;
      logic last_cmp;
      logic load_rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic n_zero;
      logic f2_lt_n;
      logic f2_gt_one;
      logic last_ok;
      logic hit;
   } dp_status_type;

endpackage

### hw/rtl/fibonacci_table_search_core.sv
// Fibonacci table search core: a table of ascending keys searched by
// Fibonacci probing. Top level; uses fts_pkg, fts_ctrl and fts_dp.
//
// Usage:
//   req channel: a write beat (tuser 0) stores key_value at entry_index;
//   indexes at or above the table depth are dropped. A search beat
//   (tuser 1) looks up key_value among the first entries_in_use keys.
//   rsp channel: one beat per search with found, position and probe count.
//   csr channel: writes entries_in_use; write it only while the core is idle.
// Sequence:
//   A write beat is stored as it is taken; a search of an empty table goes
//   straight to its result. Any other search first grows the Fibonacci terms
//   to cover the entry count (up to 15 growth steps for 1024 entries), then
//   runs loop probes until one hits or the terms run out, and on a miss a
//   closing check when the entry after the offset is in use: each probe is
//   one registered read of the key table followed by one compare.
//   The result sits in an output register, so the next item is accepted as
//   soon as the search finishes, even while the receiver stalls; a second
//   result then waits until the first beat is taken.
// Reset clears the controller, the result valid and entries_in_use; the key
// table is not cleared and holds unknown keys until written.
module fibonacci_table_search_core #(
   parameter int TABLE_DEPTH = fts_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_WIDTH   = fts_pkg::KEY_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [9:0] entry_index, [73:10] key_value, [79:74] zero
   input  logic [fts_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] mode
   input  logic [fts_pkg::MODE_W-1:0]        req_tuser,
   // Response stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [9:0] position, [14:10] probes, [15] zero
   output logic [fts_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] found
   output logic                              rsp_tuser,
   // Configuration write: entries_in_use.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fts_pkg::CSR_W-1:0]         csr_wdata
);
   import fts_pkg::*;

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic [POS_W-1:0]   rsp_position;
   logic [PROBE_W-1:0] rsp_probes;

   // The register write is always taken.
   assign csr_ready = 1'b1;

   fts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fts_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_beat     (csr_valid && csr_ready),
      .csr_wdata    (csr_wdata),
      .entry_index  (req_tdata[INDEX_W-1:0]),
      .key_value    (req_tdata[INDEX_W +: KEY_W]),
      .cmd          (cmd),
      .status       (status),
      .rsp_found    (rsp_tuser),
      .rsp_position (rsp_position),
      .rsp_probes   (rsp_probes)
   );

   // Pack the response beat.
   assign rsp_tdata = {{(RSP_DATA_W - POS_W - PROBE_W){1'b0}}, rsp_probes, rsp_position};

endmodule

### hw/rtl/fts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/fts_ctrl.sv
// Controller state machine of the Fibonacci table search core.
// Sequences the term growth, the probes and the closing check; uses fts_pkg.
module fts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_mode,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  fts_pkg::dp_status_type status,
   output fts_pkg::dp_cmd_type    cmd
);
   import fts_pkg::*;

   fsm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_beat;

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_mode == MODE_SEARCH) begin
                  cmd.start = 1'b1;
                  state_in  = ST_GROW;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_GROW: begin
            if (status.n_zero) begin
               state_in = ST_FINISH;
            end else if (status.f2_lt_n) begin
               cmd.grow = 1'b1;
            end else begin
               state_in = ST_PROBE_RD;
            end
         end
         ST_PROBE_RD: begin
            if (status.f2_gt_one) begin
               cmd.probe_rd = 1'b1;
               state_in     = ST_PROBE_CMP;
            end else begin
               state_in = ST_LAST_RD;
            end
         end
         ST_PROBE_CMP: begin
            cmd.probe_cmp = 1'b1;
            state_in      = status.hit ? ST_FINISH : ST_PROBE_RD;
         end
         ST_LAST_RD: begin
            if (status.last_ok) begin
               cmd.last_rd = 1'b1;
               state_in    = ST_LAST_CMP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_LAST_CMP: begin
            cmd.last_cmp = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // Wait until the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/fts_dp.sv
// Datapath of the Fibonacci table search core: key table, Fibonacci terms,
// search base, probe counter and result register. Uses fts_pkg and fts_ram.
module fts_dp #(
   parameter int TABLE_DEPTH = fts_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_WIDTH   = fts_pkg::KEY_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_beat,
   input  logic [fts_pkg::CSR_W-1:0]     csr_wdata,
   input  logic [fts_pkg::INDEX_W-1:0]   entry_index,
   input  logic [fts_pkg::KEY_W-1:0]     key_value,
   input  fts_pkg::dp_cmd_type           cmd,
   output fts_pkg::dp_status_type        status,
   output logic                          rsp_found,
   output logic [fts_pkg::POS_W-1:0]     rsp_position,
   output logic [fts_pkg::PROBE_W-1:0]   rsp_probes
);
   import fts_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   // Configuration register.
   logic [CSR_W-1:0]     entries_ff, entries_in;

   // Search state.
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [FIB_W-1:0]     n_ff, n_in;
   logic [FIB_W-1:0]     f0_ff, f0_in, f1_ff, f1_in, f2_ff, f2_in;
   logic [FIB_W-1:0]     base_ff, base_in;
   logic [FIB_W-1:0]     idx_ff, idx_in;
   logic [FIB_W-1:0]     pos_ff, pos_in;
   logic [PROBE_W-1:0]   probes_ff, probes_in;
   logic                 found_ff, found_in;

   // Result register.
   logic                 rsp_found_ff, rsp_found_in;
   logic [FIB_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [PROBE_W-1:0]   rsp_probes_ff, rsp_probes_in;

   // Table access.
   logic                 wr_en;
   logic [AW-1:0]        rd_addr;
   logic [KEY_WIDTH-1:0] rd_data;
   logic [FIB_W-1:0]     idx_sum, n_last, idx_next;
   logic [CSR_W-1:0]     n_sat;
   logic [PROBE_W-1:0]   probes_bump;
   logic                 lt, hit;

   fts_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_key_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(entry_index)),
      .wr_data (key_value[KEY_WIDTH-1:0]),
      .rd_en   (cmd.probe_rd || cmd.last_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Writes beyond the table are dropped.
   assign wr_en = cmd.write && (32'(entry_index) < TABLE_DEPTH);

   // Probe index: offset plus f0, clamped to the last entry in use.
   assign idx_sum  = base_ff + f0_ff - FIB_W'(1);
   assign n_last   = n_ff - FIB_W'(1);
   assign idx_next = (idx_sum > n_last) ? n_last : idx_sum;
   assign rd_addr  = cmd.last_rd ? AW'(base_ff) : AW'(idx_next);

   // Entry count saturates at the table depth.
   assign n_sat = (32'(entries_ff) > TABLE_DEPTH) ? CSR_W'(TABLE_DEPTH) : entries_ff;

   assign lt          = rd_data < key_ff;
   assign hit         = rd_data == key_ff;
   assign probes_bump = (probes_ff == PROBE_MAX) ? probes_ff : probes_ff + PROBE_W'(1);

   // Status toward the controller.
   always_comb begin
      status.n_zero    = (n_ff == '0);
      status.f2_lt_n   = (f2_ff < n_ff);
      status.f2_gt_one = (f2_ff > FIB_W'(1));
      status.last_ok   = (f1_ff != '0) && (base_ff < n_ff);
      status.hit       = hit;
   end

   // Next values of the search state.
   always_comb begin
      entries_in    = csr_beat ? csr_wdata : entries_ff;
      key_in        = key_ff;
      n_in          = n_ff;
      f0_in         = f0_ff;
      f1_in         = f1_ff;
      f2_in         = f2_ff;
      base_in       = base_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      probes_in     = probes_ff;
      found_in      = found_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_probes_in = rsp_probes_ff;

      if (cmd.start) begin
         key_in    = key_value[KEY_WIDTH-1:0];
         n_in      = FIB_W'(n_sat);
         f0_in     = '0;
         f1_in     = FIB_W'(1);
         f2_in     = FIB_W'(1);
         base_in   = '0;
         pos_in    = '0;
         probes_in = '0;
         found_in  = 1'b0;
      end

      // Step the terms up until f2 covers the entries in use.
      if (cmd.grow) begin
         f0_in = f1_ff;
         f1_in = f2_ff;
         f2_in = f1_ff + f2_ff;
      end

      if (cmd.probe_rd) begin
         idx_in = idx_next;
      end

      // Narrow the window by one or two Fibonacci steps, or stop on a match.
      if (cmd.probe_cmp) begin
         probes_in = probes_bump;
         if (hit) begin
            found_in = 1'b1;
            pos_in   = idx_ff;
         end else if (lt) begin
            f2_in   = f1_ff;
            f1_in   = f0_ff;
            f0_in   = f1_ff - f0_ff;
            base_in = idx_ff + FIB_W'(1);
         end else begin
            f2_in = f0_ff;
            f1_in = f1_ff - f0_ff;
            f0_in = f0_ff - (f1_ff - f0_ff);
         end
      end

      // Closing check of the entry just after the offset.
      if (cmd.last_cmp) begin
         probes_in = probes_bump;
         if (hit) begin
            found_in = 1'b1;
            pos_in   = base_ff;
         end
      end

      if (cmd.load_rsp) begin
         rsp_found_in  = found_ff;
         rsp_pos_in    = found_ff ? pos_ff : '0;
         rsp_probes_in = probes_ff;
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
      end else begin
         entries_ff <= entries_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      n_ff          <= n_in;
      f0_ff         <= f0_in;
      f1_ff         <= f1_in;
      f2_ff         <= f2_in;
      base_ff       <= base_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      probes_ff     <= probes_in;
      found_ff      <= found_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_probes_ff <= rsp_probes_in;
   end

   assign rsp_found    = rsp_found_ff;
   assign rsp_position = POS_W'(rsp_pos_ff);
   assign rsp_probes   = rsp_probes_ff;

endmodule

### tb/testbench.sv
// Self-checking testbench for the Fibonacci table search core.
// Drives write and search beats, predicts each search result unless a directed row gives it, and checks the responses.
// Depends on fts_pkg and fibonacci_table_search_core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fts_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int DRAIN_CYCLES    = 80;
   localparam int SETTLE_CYCLES   = 4;
   localparam int PHASE_COUNT     = 20;
   localparam int PHASE_ITEMS     = 38;
   localparam int PRESSURE_PHASE  = 14;
   localparam int RANDOM_COUNT    = -1;

   typedef struct packed {
      logic               found;
      logic [POS_W-1:0]   position;
      logic [PROBE_W-1:0] probes;
   } lookup_result_type;

   typedef enum {ROW_COUNT, ROW_ITEM} row_kind_type;

   // One directed step; a count row carries the new entry count in key.
   typedef struct {
      row_kind_type       kind;
      logic               mode;
      logic [INDEX_W-1:0] index;
      logic [KEY_W-1:0]   key;
      bit                 typed;
      lookup_result_type  result;
   } stim_row_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_W-1:0]      csr_wdata  = '0;

   // Mirror of the key table and the entry count, and the searches in flight.
   bit [KEY_W-1:0]    key_mirror [TABLE_DEPTH_DEF];
   logic [CSR_W-1:0]  mirror_count = '0;
   lookup_result_type pending_lookups [$];
   stim_row_type      directed_rows [$];
   lookup_result_type seen_result;
   lookup_result_type wanted_result;

   int error_count      = 0;
   int idle_cycles      = 0;
   bit steady_phase     = 1'b0;
   bit hold_off_pending = 1'b0;

   fibonacci_table_search_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Fibonacci search over the mirrored table, probe for probe.
   function automatic lookup_result_type predict_search(logic [KEY_W-1:0] key);
      int n, f0, f1, f2, offset, idx, probes, pos;
      bit hit;
      lookup_result_type r;
      n = (mirror_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(mirror_count);
      probes = 0;
      pos = 0;
      hit = 1'b0;
      if (n > 0) begin
         f0 = 0;
         f1 = 1;
         f2 = 1;
         while (f2 < n) begin
            f0 = f1;
            f1 = f2;
            f2 = f1 + f0;
         end
         offset = -1;
         while (f2 > 1 && !hit) begin
            idx = offset + f0;
            if (idx > n - 1) idx = n - 1;
            probes++;
            if (key_mirror[idx] < key) begin
               f2 = f1;
               f1 = f0;
               f0 = f2 - f1;
               offset = idx;
            end else if (key_mirror[idx] > key) begin
               f2 = f0;
               f1 = f1 - f0;
               f0 = f2 - f1;
            end else begin
               hit = 1'b1;
               pos = idx;
            end
         end
         // Closing check on the entry after the offset, if it is in use.
         if (!hit && f1 != 0 && offset + 1 < n) begin
            probes++;
            if (key_mirror[offset + 1] == key) begin
               hit = 1'b1;
               pos = offset + 1;
            end
         end
      end
      r.found    = hit;
      r.position = hit ? pos[POS_W-1:0] : '0;
      r.probes   = (probes > 31) ? PROBE_MAX : probes[PROBE_W-1:0];
      return r;
   endfunction

   function automatic void add_row(row_kind_type kind, logic mode, logic [INDEX_W-1:0] index,
                                   logic [KEY_W-1:0] key, bit typed = 1'b0,
                                   logic found = 1'b0, logic [POS_W-1:0] position = '0,
                                   logic [PROBE_W-1:0] probes = '0);
      stim_row_type row;
      row.kind   = kind;
      row.mode   = mode;
      row.index  = index;
      row.key    = key;
      row.typed  = typed;
      row.result = '{found: found, position: position, probes: probes};
      directed_rows.push_back(row);
   endfunction

   // Sender gap: mostly none or short, now and then long.
   function automatic int next_gap();
      int r;
      if (steady_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   // Offer one request beat, record its effect once taken, then maybe idle.
   task automatic issue_item(logic mode, logic [INDEX_W-1:0] index, logic [KEY_W-1:0] key,
                             bit typed = 1'b0, lookup_result_type typed_result = '0);
      int gap;
      req_tuser  <= mode;
      req_tdata  <= {6'b0, key, index};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (mode == MODE_WRITE) key_mirror[index] = key;
      else pending_lookups.push_back(typed ? typed_result : predict_search(key));
      @(negedge clock);
      gap = next_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Change the entry count once the core has drained.
   task automatic write_entry_count(logic [CSR_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_lookups.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      mirror_count = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Response side: random stalls, quiet stretches and one long hold-off.
   initial begin
      int r;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (steady_phase) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(20, 60)) @(negedge clock);
            end else begin
               rsp_tready <= (r >= 25);
            end
         end
      end
   end

   // Check every response beat against the oldest outstanding search.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lookups.size() == 0) begin
            $error("response beat with no search outstanding");
            error_count++;
         end else begin
            wanted_result = pending_lookups.pop_front();
            seen_result   = '{found: rsp_tuser, position: rsp_tdata[POS_W-1:0],
                              probes: rsp_tdata[POS_W +: PROBE_W]};
            if (seen_result.found !== wanted_result.found) begin
               $error("found: expected %0d, got %0d", wanted_result.found, seen_result.found);
               error_count++;
            end
            if (seen_result.position !== wanted_result.position) begin
               $error("position: expected %0d, got %0d",
                      wanted_result.position, seen_result.position);
               error_count++;
            end
            if (seen_result.probes !== wanted_result.probes) begin
               $error("probes: expected %0d, got %0d",
                      wanted_result.probes, seen_result.probes);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run after too many cycles without any beat.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // Main stimulus.
   initial begin
      int n_eff, r, count_sel;
      logic [KEY_W-1:0] key, lo, hi;
      logic [INDEX_W-1:0] idx;
      int phase_counts [PHASE_COUNT] = '{0, 1, 2, 3, 5, 8, 13, 21, 34, 89, 144, 377, 610,
                                         1000, 1024, 1023, 1025, 1536, 2047, RANDOM_COUNT};

      // Directed rows. Keys spell short IDs such as "ID0001", zero padded.
      add_row(ROW_ITEM, MODE_SEARCH, 0, '0, 1, 0, 0, 0);
      add_row(ROW_ITEM, MODE_SEARCH, 0, '1, 1, 0, 0, 0);
      add_row(ROW_ITEM, MODE_WRITE, 0, '0);
      add_row(ROW_ITEM, MODE_WRITE, 1, 64'h4944_3030_3031_0000);
      add_row(ROW_ITEM, MODE_WRITE, 2, 64'h4944_3030_3032_0000);
      add_row(ROW_ITEM, MODE_WRITE, 3, 64'h4944_3030_3033_0000);
      add_row(ROW_COUNT, MODE_WRITE, 0, 64'd1);
      add_row(ROW_ITEM, MODE_SEARCH, 0, '0, 1, 1, 0, 1);
      add_row(ROW_ITEM, MODE_SEARCH, 0, '1, 1, 0, 0, 1);
      add_row(ROW_COUNT, MODE_WRITE, 0, 64'd4);
      add_row(ROW_ITEM, MODE_SEARCH, 0, '0);
      add_row(ROW_ITEM, MODE_SEARCH, 0, 64'h4944_3030_3031_0000);
      add_row(ROW_ITEM, MODE_SEARCH, 0, 64'h4944_3030_3032_0000);
      add_row(ROW_ITEM, MODE_SEARCH, 0, 64'h4944_3030_3033_0000);
      // Key above every entry: the closing check falls off the table end.
      add_row(ROW_ITEM, MODE_SEARCH, 0, '1);
      add_row(ROW_ITEM, MODE_SEARCH, 0, 64'h4944_3030_3031_0001);
      add_row(ROW_ITEM, MODE_SEARCH, 0, 64'd1);
      // Break the ordering and search through it.
      add_row(ROW_ITEM, MODE_WRITE, 2, '1);
      add_row(ROW_ITEM, MODE_SEARCH, 0, 64'h4944_3030_3033_0000);
      add_row(ROW_ITEM, MODE_SEARCH, 0, 64'h4944_3030_3032_0000);
      // Back to an empty table.
      add_row(ROW_COUNT, MODE_WRITE, 0, 64'd0);
      add_row(ROW_ITEM, MODE_SEARCH, 0, 64'h4944_3030_3031_0000, 1, 0, 0, 0);

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_COUNT)
            write_entry_count(directed_rows[i].key[CSR_W-1:0]);
         else
            issue_item(directed_rows[i].mode, directed_rows[i].index, directed_rows[i].key,
                       directed_rows[i].typed, directed_rows[i].result);
      end

      // Fill the whole table with strictly ascending keys.
      for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
         key = {$urandom, $urandom};
         key[KEY_W-1 -: INDEX_W] = i[INDEX_W-1:0];
         issue_item(MODE_WRITE, i[INDEX_W-1:0], key);
      end

      // Random phases, each at its own entry count.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         steady_phase = (ph % 4 == 3) || (ph == PRESSURE_PHASE);
         count_sel = (phase_counts[ph] == RANDOM_COUNT) ? $urandom_range(1, 2047)
                                                        : phase_counts[ph];
         write_entry_count(count_sel[CSR_W-1:0]);
         if (ph == PRESSURE_PHASE) hold_off_pending = 1'b1;
         n_eff = (mirror_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(mirror_count);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
               // Write: mostly keeps the order, sometimes a random key.
               if (n_eff > 0 && $urandom_range(0, 9) < 7)
                  idx = INDEX_W'($urandom_range(0, n_eff - 1));
               else
                  idx = INDEX_W'($urandom_range(0, TABLE_DEPTH_DEF - 1));
               lo  = (idx > 0) ? key_mirror[idx - 1] : '0;
               hi  = (idx < TABLE_DEPTH_DEF - 1) ? key_mirror[idx + 1] : '1;
               key = {$urandom, $urandom};
               if ($urandom_range(0, 3) != 0)
                  key = (hi > lo + 1) ? lo + 1 + key % (hi - lo - 1) : key_mirror[idx];
               issue_item(MODE_WRITE, idx, key);
            end else begin
               // Search: mostly keys in use, then near misses and outliers.
               r = $urandom_range(0, 99);
               key = {$urandom, $urandom};
               if (n_eff > 0 && r < 55) begin
                  key = key_mirror[$urandom_range(0, n_eff - 1)];
               end else if (n_eff > 0 && r < 70) begin
                  key = key_mirror[$urandom_range(0, n_eff - 1)];
                  key = ($urandom_range(0, 1) != 0) ? key + 1 : key - 1;
               end else if (n_eff < TABLE_DEPTH_DEF && r < 80) begin
                  key = key_mirror[$urandom_range(n_eff, TABLE_DEPTH_DEF - 1)];
               end else if (r >= 90) begin
                  key = ($urandom_range(0, 1) != 0) ? '1 : '0;
               end
               issue_item(MODE_SEARCH, INDEX_W'($urandom_range(0, TABLE_DEPTH_DEF - 1)), key);
            end
         end
      end

      // Drain and finish.
      req_tvalid <= 1'b0;
      while (pending_lookups.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

### sim.f
hw/rtl/fts_pkg.sv
hw/rtl/fts_ram.sv
hw/rtl/fts_ctrl.sv
hw/rtl/fts_dp.sv
hw/rtl/fibonacci_table_search_core.sv
tb/testbench.sv
